@@ design/hopl_pkg.sv @@
// ----------------------------------------------------------------------------
// hopl_pkg
// Shared types, character constants and per-byte parse functions for the
// handshake option line parser.
// ----------------------------------------------------------------------------
package hopl_pkg;

	localparam int PREFIX_LEN      = 15;
	localparam int MIN_LINE_BUFFER = 64;
	localparam int KW_COUNT        = 6;
	localparam int MTU_BIT         = 6;
	localparam int MTU_LEN         = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// greeting prefix, first character in the top byte
	localparam logic [8*PREFIX_LEN-1:0] PREFIX_TEXT =
		120'h53_54_41_52_54_42_44_51_53_20_2F_31_2E_30_2F;
	localparam logic [8*MTU_LEN-1:0] MTU_TEXT = "MTU=";
	localparam logic [15:0] MTU_MAX = 16'hFFFF;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_ERR = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  option_flags;
		logic        mtu_present;
		logic [15:0] remote_mtu;
	} hopl_result_t;

	typedef struct packed {
		logic        prefix_match;
		logic        prefix_done;
		logic        string_ended;
		logic [7:0]  token_position;
		logic [6:0]  keyword_candidates;
		logic        mtu_digits_stopped;
		logic [15:0] mtu_accumulator;
		logic [5:0]  flag_accumulator;
		logic        mtu_seen;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		prefix_match:       1'b1,
		prefix_done:        1'b0,
		string_ended:       1'b0,
		token_position:     8'd0,
		keyword_candidates: 7'h7F,
		mtu_digits_stopped: 1'b0,
		mtu_accumulator:    16'd0,
		flag_accumulator:   6'd0,
		mtu_seen:           1'b0
	};

	function automatic logic [7:0] kw_len(input int unsigned k);
		unique case (k)
			0: return 8'd2;
			1: return 8'd10;
			2: return 8'd6;
			3: return 8'd7;
			4: return 8'd4;
			5: return 8'd6;
			default: return 8'd0;
		endcase
	endfunction

	// keywords left aligned in ten bytes
	function automatic logic [79:0] kw_text(input int unsigned k);
		unique case (k)
			0: return {"LE", 64'h0};
			1: return "MULTIQUERY";
			2: return {"SELECT", 32'h0};
			3: return {"COLLATE", 24'h0};
			4: return {"EVAL", 48'h0};
			5: return {"EVENTS", 32'h0};
			default: return 80'h0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] p);
		logic [79:0] t;
		t = kw_text(k);
		if (p > 4'd9)
			return 8'h00;
		return t[8*(9-int'(p)) +: 8];
	endfunction

	function automatic logic [7:0] prefix_char(input logic [3:0] p);
		if (int'(p) > PREFIX_LEN-1)
			return 8'h00;
		return PREFIX_TEXT[8*(PREFIX_LEN-1-int'(p)) +: 8];
	endfunction

	function automatic logic [7:0] mtu_char(input logic [1:0] p);
		return MTU_TEXT[8*(MTU_LEN-1-int'(p)) +: 8];
	endfunction

	function automatic parse_state_t close_token(input parse_state_t s);
		parse_state_t r;
		r = s;
		if (s.token_position != 8'd0) begin
			for (int unsigned k = 0; k < KW_COUNT; k++) begin
				if (s.keyword_candidates[k] && s.token_position == kw_len(k))
					r.flag_accumulator[k] = 1'b1;
			end
		end
		r.token_position     = 8'd0;
		r.keyword_candidates = 7'h7F;
		r.mtu_digits_stopped = 1'b0;
		return r;
	endfunction

	function automatic parse_state_t token_char(input parse_state_t s, input logic [7:0] c);
		parse_state_t r;
		logic [7:0]   p;
		logic [19:0]  prod;
		r = s;
		p = s.token_position;
		for (int unsigned k = 0; k < KW_COUNT; k++) begin
			if (p >= kw_len(k))
				r.keyword_candidates[k] = 1'b0;
			else if (kw_char(k, p[3:0]) != c)
				r.keyword_candidates[k] = 1'b0;
		end
		prod = ({4'b0, s.mtu_accumulator} << 3) + ({4'b0, s.mtu_accumulator} << 1)
			+ {16'b0, c[3:0]};
		if (s.keyword_candidates[MTU_BIT]) begin
			if (p < 8'(MTU_LEN)) begin
				if (mtu_char(p[1:0]) != c) begin
					r.keyword_candidates[MTU_BIT] = 1'b0;
				end else if (p == 8'(MTU_LEN-1)) begin
					r.mtu_seen           = 1'b1;
					r.mtu_accumulator    = 16'd0;
					r.mtu_digits_stopped = 1'b0;
				end
			end else if (!s.mtu_digits_stopped) begin
				if (c >= CH_0 && c <= CH_9)
					r.mtu_accumulator = (prod > {4'b0, MTU_MAX}) ? MTU_MAX : prod[15:0];
				else
					r.mtu_digits_stopped = 1'b1;
			end
		end
		if (p != 8'hFF)
			r.token_position = p + 8'd1;
		return r;
	endfunction

	function automatic parse_state_t commit_char(input parse_state_t s, input logic [7:0] c);
		parse_state_t r;
		r = s;
		if (!s.string_ended) begin
			if (c == CH_NUL) begin
				r.string_ended = 1'b1;
				if (s.prefix_done)
					r = close_token(r);
			end else if (!s.prefix_done) begin
				if (prefix_char(s.token_position[3:0]) != c)
					r.prefix_match = 1'b0;
				r.token_position = s.token_position + 8'd1;
				if (s.token_position + 8'd1 >= 8'(PREFIX_LEN)) begin
					r.prefix_done        = 1'b1;
					r.token_position     = 8'd0;
					r.keyword_candidates = 7'h7F;
					r.mtu_digits_stopped = 1'b0;
				end
			end else if (c == CH_SLASH) begin
				r = close_token(s);
			end else begin
				r = token_char(s, c);
			end
		end
		return r;
	endfunction

	function automatic hopl_result_t make_result(input parse_state_t s, input logic [1:0] status);
		hopl_result_t r;
		logic         ok;
		ok = (status == ST_OK);
		r.status       = status;
		r.option_flags = ok ? s.flag_accumulator : 6'd0;
		r.mtu_present  = ok && s.mtu_seen;
		r.remote_mtu   = (ok && s.mtu_seen) ? s.mtu_accumulator : 16'd0;
		return r;
	endfunction

endpackage

@@ design/hopl_parse.sv @@
// ----------------------------------------------------------------------------
// hopl_parse
// Line parse state and the per-byte update; raises one result at the end of
// a handshake, on a read failure or on line overflow, then rearms.
// ----------------------------------------------------------------------------
module hopl_parse #(
	parameter int LINE_BUFFER_BYTES = 160
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_kind,
	input  logic [7:0]             item_byte,
	input  logic                   out_free,
	output logic                   item_take,
	output logic                   res_fire,
	output hopl_pkg::hopl_result_t res
);

	localparam int LLW = $clog2(LINE_BUFFER_BYTES + 1);
	localparam logic [LLW-1:0] LINE_LIMIT = LLW'(LINE_BUFFER_BYTES);
	localparam bit SMALL_BUFFER = (LINE_BUFFER_BYTES < hopl_pkg::MIN_LINE_BUFFER);

	localparam logic [1:0] PH_LINE     = 2'd0;
	localparam logic [1:0] PH_BLANK    = 2'd1;
	localparam logic [1:0] PH_BLANK_CR = 2'd2;

	logic [1:0]              phase_q, phase_d;
	logic [LLW-1:0]          line_length_q, line_length_d, line_inc;
	logic                    pending_cr_q, pending_cr_d;
	hopl_pkg::parse_state_t  ps_q, ps_d, ps_cr;
	logic                    res_valid;

	always_comb begin
		phase_d       = phase_q;
		line_length_d = line_length_q;
		pending_cr_d  = pending_cr_q;
		ps_d          = ps_q;
		res_valid     = 1'b0;
		res           = hopl_pkg::make_result(ps_q, hopl_pkg::ST_ERR);
		line_inc      = line_length_q + LLW'(1);
		ps_cr         = pending_cr_q ? hopl_pkg::commit_char(ps_q, hopl_pkg::CH_CR) : ps_q;
		if (item_valid) begin
			if (SMALL_BUFFER || item_kind) begin
				res_valid = 1'b1;
			end else begin
				unique case (phase_q)
					PH_LINE: begin
						if (item_byte == hopl_pkg::CH_LF) begin
							pending_cr_d = 1'b0;
							if (!ps_q.string_ended && ps_q.prefix_done)
								ps_d = hopl_pkg::close_token(ps_q);
							ps_d.string_ended = 1'b1;
							phase_d = PH_BLANK;
						end else if (line_inc >= LINE_LIMIT) begin
							res_valid = 1'b1;
							res = hopl_pkg::make_result(ps_q, hopl_pkg::ST_OVF);
						end else begin
							line_length_d = line_inc;
							pending_cr_d  = (item_byte == hopl_pkg::CH_CR);
							ps_d = (item_byte == hopl_pkg::CH_CR) ? ps_cr
								: hopl_pkg::commit_char(ps_cr, item_byte);
						end
					end
					PH_BLANK: begin
						if (item_byte == hopl_pkg::CH_CR) begin
							phase_d = PH_BLANK_CR;
						end else begin
							res_valid = 1'b1;
							if (item_byte == hopl_pkg::CH_LF)
								res = hopl_pkg::make_result(ps_q,
									(ps_q.prefix_match && ps_q.prefix_done)
									? hopl_pkg::ST_OK : hopl_pkg::ST_ERR);
						end
					end
					default: begin
						res_valid = 1'b1;
						if (item_byte == hopl_pkg::CH_LF)
							res = hopl_pkg::make_result(ps_q,
								(ps_q.prefix_match && ps_q.prefix_done)
								? hopl_pkg::ST_OK : hopl_pkg::ST_ERR);
					end
				endcase
			end
		end
		// every result ends the handshake
		if (res_valid) begin
			phase_d       = PH_LINE;
			line_length_d = '0;
			pending_cr_d  = 1'b0;
			ps_d          = hopl_pkg::PARSE_RESET;
		end
	end

	// a byte that raises a result waits while the result register is full
	assign item_take = item_valid && (!res_valid || out_free);
	assign res_fire  = item_take && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LINE;
			line_length_q <= '0;
			pending_cr_q  <= 1'b0;
			ps_q          <= hopl_pkg::PARSE_RESET;
		end else if (item_take) begin
			phase_q       <= phase_d;
			line_length_q <= line_length_d;
			pending_cr_q  <= pending_cr_d;
			ps_q          <= ps_d;
		end
	end

`ifndef SYNTH
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> (phase_q == PH_LINE && line_length_q == '0 && !pending_cr_q))
		else $error("parser did not rearm after a result");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && res.status != hopl_pkg::ST_OK) |->
		(res.option_flags == 6'd0 && !res.mtu_present && res.remote_mtu == 16'd0))
		else $error("error result carries option data");

	a_mtu_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ps_q.mtu_seen |-> ps_q.mtu_accumulator == 16'd0)
		else $error("MTU value without an MTU token");

	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_length_q < LINE_LIMIT)
		else $error("line length passed the buffer size");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_take) |=> $stable(phase_q) && $stable(line_length_q))
		else $error("parse state moved during a stall");
`endif

endmodule

@@ design/hopl_out.sv @@
// ----------------------------------------------------------------------------
// hopl_out
// Result register on the master side; frees as soon as the result is taken.
// ----------------------------------------------------------------------------
module hopl_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  hopl_pkg::hopl_result_t res,
	input  logic                   take,
	output logic                   out_free,
	output logic                   valid_q,
	output hopl_pkg::hopl_result_t res_q
);

	assign out_free = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ design/handshake_option_line_parser_core.sv @@
// Path: the byte that completes the handshake passes the input register, then
// the result register, and its result then appears on the master side.
// Throughput: one byte per cycle; the byte that raises a result waits only
// while the previous result is still held in the result register.
// Reset: arst_n clears both registers' valid flags and rearms the parser.
// ----------------------------------------------------------------------------
// handshake_option_line_parser_core
// Parses the greeting line of a connect handshake into option flags and MTU.
// ----------------------------------------------------------------------------
module handshake_option_line_parser_core #(
	parameter int LINE_BUFFER_BYTES = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [5:0] option_flags, [6] mtu_present,
	                               // [22:7] remote_mtu, [23] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic                   valid_s1;
	logic                   kind_s1;
	logic [7:0]             byte_s1;
	logic                   item_take;
	logic                   res_fire;
	logic                   out_free;
	hopl_pkg::hopl_result_t res;
	hopl_pkg::hopl_result_t res_q;

	assign s_tready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	hopl_parse #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_kind  (kind_s1),
		.item_byte  (byte_s1),
		.out_free   (out_free),
		.item_take  (item_take),
		.res_fire   (res_fire),
		.res        (res)
	);

	hopl_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_fire),
		.res      (res),
		.take     (m_tready),
		.out_free (out_free),
		.valid_q  (m_tvalid),
		.res_q    (res_q)
	);

	assign m_tdata = {1'b0, res_q.remote_mtu, res_q.mtu_present, res_q.option_flags};
	assign m_tuser = res_q.status;

endmodule
